// ----- hdl/cct_pkg.sv -----
`timescale 1ns / 1ps
// Package for the circle collision test core: item types, widths, helpers.
// No dependencies; every hdl file uses it through scoped names.
package cct_pkg;

  // other shape kinds
  localparam logic [1:0] KIND_CIRCLE = 2'd0;
  localparam logic [1:0] KIND_BOX    = 2'd1;

  localparam int SCALE_BITS = 8;
  localparam int NORM_BITS  = 14;
  localparam int MAG_W      = 34;              // |dx| <= 2^33
  localparam int SQ_W       = 2 * MAG_W;       // dx^2 + dy^2
  localparam int RAD_W      = 40;              // scaled radius sum
  localparam int RSQ_W      = 2 * RAD_W;
  localparam int DIST_W     = 35;              // floor(sqrt(SQ))
  localparam int QUO_W      = NORM_BITS + 1;   // normal magnitude <= 2^14
  localparam int PROD_W     = QUO_W + 31;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] self_x;
    logic signed [31:0] self_y;
    logic [30:0]        self_radius;
    logic [15:0]        self_scale;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic [30:0]        other_radius;
    logic [30:0]        other_width;
    logic [30:0]        other_height;
    logic [15:0]        other_scale_x;
    logic [15:0]        other_scale_y;
  } in_t;

  typedef struct packed {
    logic               colliding;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [31:0] depth;
  } out_t;

  // per-item context that rides along the pipeline
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] base_x;     // other center (circle) or clamped point (box)
    logic signed [31:0] base_y;
    logic [30:0]        self_radius;
    logic               neg_x;
    logic               neg_y;
    logic [MAG_W-1:0]   mag_x;
    logic [MAG_W-1:0]   mag_y;
    logic [RAD_W-1:0]   rad;        // radius the distance is measured against
    logic               hit;
  } ctx_t;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -42'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/cct_front.sv -----
`timescale 1ns / 1ps
// Front end: scaling, box clamp, offsets, squared distance and overlap test.
// Seven register stages. Depends on cct_pkg.
module cct_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  cct_pkg::in_t              in_i,
  output logic                      valid_o,
  output cct_pkg::ctx_t             ctx_o,
  output logic [cct_pkg::SQ_W-1:0]  dsq_o
);

  logic [6:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  // stage 1: scaled radii and box half sizes
  logic [46:0] own_p, orad_p, hw_p, hh_p;
  assign own_p  = 47'(in_i.self_radius)  * 47'(in_i.self_scale);
  assign orad_p = 47'(in_i.other_radius) * 47'(in_i.other_scale_x);
  assign hw_p   = 47'(in_i.other_width)  * 47'(in_i.other_scale_x);
  assign hh_p   = 47'(in_i.other_height) * 47'(in_i.other_scale_y);

  logic [1:0]         kind1_q;
  logic signed [31:0] sx1_q, sy1_q, ox1_q, oy1_q;
  logic [30:0]        sr1_q;
  logic [38:0]        own1_q, orad1_q;
  logic [37:0]        hw1_q, hh1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind1_q <= in_i.action;
      sx1_q   <= in_i.self_x;
      sy1_q   <= in_i.self_y;
      ox1_q   <= in_i.other_x;
      oy1_q   <= in_i.other_y;
      sr1_q   <= in_i.self_radius;
      own1_q  <= own_p[46:cct_pkg::SCALE_BITS];
      orad1_q <= orad_p[46:cct_pkg::SCALE_BITS];
      hw1_q   <= hw_p[46:cct_pkg::SCALE_BITS+1];
      hh1_q   <= hh_p[46:cct_pkg::SCALE_BITS+1];
    end
  end

  // stage 2: radius sum, box bounds
  logic signed [40:0] ox1_w, oy1_w, hw1_w, hh1_w;
  assign ox1_w = {{9{ox1_q[31]}}, ox1_q};
  assign oy1_w = {{9{oy1_q[31]}}, oy1_q};
  assign hw1_w = $signed({3'b000, hw1_q});
  assign hh1_w = $signed({3'b000, hh1_q});

  logic [1:0]                 kind2_q;
  logic signed [31:0]         sx2_q, sy2_q, ox2_q, oy2_q;
  logic [30:0]                sr2_q;
  logic [cct_pkg::RAD_W-1:0]  rad2_q;
  logic signed [40:0]         lox2_q, hix2_q, loy2_q, hiy2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind2_q <= kind1_q;
      sx2_q   <= sx1_q;
      sy2_q   <= sy1_q;
      ox2_q   <= ox1_q;
      oy2_q   <= oy1_q;
      sr2_q   <= sr1_q;
      rad2_q  <= (kind1_q == cct_pkg::KIND_CIRCLE) ?
                 (40'(own1_q) + 40'(orad1_q)) : 40'(own1_q);
      lox2_q  <= ox1_w - hw1_w;
      hix2_q  <= ox1_w + hw1_w;
      loy2_q  <= oy1_w - hh1_w;
      hiy2_q  <= oy1_w + hh1_w;
    end
  end

  // stage 3: clamp into the box, offset from the reference point
  logic signed [40:0] sx2_w, sy2_w, ox2_w, oy2_w, tx_w, ty_w;
  logic               circ2;
  assign sx2_w = {{9{sx2_q[31]}}, sx2_q};
  assign sy2_w = {{9{sy2_q[31]}}, sy2_q};
  assign ox2_w = {{9{ox2_q[31]}}, ox2_q};
  assign oy2_w = {{9{oy2_q[31]}}, oy2_q};
  assign circ2 = (kind2_q == cct_pkg::KIND_CIRCLE);

  always_comb begin
    if (sx2_w < lox2_q) begin
      tx_w = lox2_q;
    end else if (sx2_w > hix2_q) begin
      tx_w = hix2_q;
    end else begin
      tx_w = sx2_w;
    end
    if (sy2_w < loy2_q) begin
      ty_w = loy2_q;
    end else if (sy2_w > hiy2_q) begin
      ty_w = hiy2_q;
    end else begin
      ty_w = sy2_w;
    end
  end

  logic [1:0]                kind3_q;
  logic signed [31:0]        bx3_q, by3_q;
  logic [30:0]               sr3_q;
  logic [cct_pkg::RAD_W-1:0] rad3_q;
  logic signed [40:0]        dx3_q, dy3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind3_q <= kind2_q;
      sr3_q   <= sr2_q;
      rad3_q  <= rad2_q;
      // clamped point lies between own and other center, so it fits 32 bits
      bx3_q   <= circ2 ? ox2_q : tx_w[31:0];
      by3_q   <= circ2 ? oy2_q : ty_w[31:0];
      dx3_q   <= sx2_w - (circ2 ? ox2_w : tx_w);
      dy3_q   <= sy2_w - (circ2 ? oy2_w : ty_w);
    end
  end

  // stage 4: sign and magnitude
  logic signed [40:0] adx_w, ady_w;
  assign adx_w = dx3_q[40] ? -dx3_q : dx3_q;
  assign ady_w = dy3_q[40] ? -dy3_q : dy3_q;

  cct_pkg::ctx_t ctx4_q, ctx5_q, ctx6_q, ctx7_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx4_q.kind        <= kind3_q;
      ctx4_q.base_x      <= bx3_q;
      ctx4_q.base_y      <= by3_q;
      ctx4_q.self_radius <= sr3_q;
      ctx4_q.neg_x       <= dx3_q[40];
      ctx4_q.neg_y       <= dy3_q[40];
      ctx4_q.mag_x       <= adx_w[cct_pkg::MAG_W-1:0];
      ctx4_q.mag_y       <= ady_w[cct_pkg::MAG_W-1:0];
      ctx4_q.rad         <= rad3_q;
      ctx4_q.hit         <= 1'b0;
    end
  end

  // stage 5: partial products (each factor at most 32 bits)
  logic [63:0] xll5_q, yll5_q;
  logic [33:0] xlh5_q, ylh5_q;
  logic [3:0]  xhh5_q, yhh5_q;
  logic [39:0] rhh5_q, rhl5_q, rll5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx5_q <= ctx4_q;
      xll5_q <= 64'(ctx4_q.mag_x[31:0]) * 64'(ctx4_q.mag_x[31:0]);
      xlh5_q <= 34'(ctx4_q.mag_x[31:0]) * 34'(ctx4_q.mag_x[33:32]);
      xhh5_q <= 4'(ctx4_q.mag_x[33:32]) * 4'(ctx4_q.mag_x[33:32]);
      yll5_q <= 64'(ctx4_q.mag_y[31:0]) * 64'(ctx4_q.mag_y[31:0]);
      ylh5_q <= 34'(ctx4_q.mag_y[31:0]) * 34'(ctx4_q.mag_y[33:32]);
      yhh5_q <= 4'(ctx4_q.mag_y[33:32]) * 4'(ctx4_q.mag_y[33:32]);
      rhh5_q <= 40'(ctx4_q.rad[39:20]) * 40'(ctx4_q.rad[39:20]);
      rhl5_q <= 40'(ctx4_q.rad[39:20]) * 40'(ctx4_q.rad[19:0]);
      rll5_q <= 40'(ctx4_q.rad[19:0]) * 40'(ctx4_q.rad[19:0]);
    end
  end

  // stage 6: assemble squares
  logic [cct_pkg::SQ_W-1:0]  x2_6_q, y2_6_q;
  logic [cct_pkg::RSQ_W-1:0] r2_6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx6_q <= ctx5_q;
      x2_6_q <= 68'(xll5_q) + (68'(xlh5_q) << 33) + (68'(xhh5_q) << 64);
      y2_6_q <= 68'(yll5_q) + (68'(ylh5_q) << 33) + (68'(yhh5_q) << 64);
      r2_6_q <= (80'(rhh5_q) << 40) + (80'(rhl5_q) << 21) + 80'(rll5_q);
    end
  end

  // stage 7: squared distance and overlap (strict for circles)
  logic [cct_pkg::SQ_W-1:0] dsq_w;
  logic [cct_pkg::SQ_W-1:0] dsq7_q;
  cct_pkg::ctx_t            ctx7_d;
  assign dsq_w = x2_6_q + y2_6_q;

  always_comb begin
    ctx7_d     = ctx6_q;
    ctx7_d.hit = (ctx6_q.kind == cct_pkg::KIND_CIRCLE) ?
                 (80'(dsq_w) < r2_6_q) : (80'(dsq_w) <= r2_6_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx7_q <= ctx7_d;
      dsq7_q <= dsq_w;
    end
  end

  assign valid_o = v_q[6];
  assign ctx_o   = ctx7_q;
  assign dsq_o   = dsq7_q;

endmodule

// ----- hdl/cct_sqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
// Depends on cct_pkg.
module cct_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  cct_pkg::ctx_t               ctx_i,
  input  logic [cct_pkg::SQ_W-1:0]    dsq_i,
  output logic                        valid_o,
  output cct_pkg::ctx_t               ctx_o,
  output logic [cct_pkg::DIST_W-1:0]  dist_o
);

  localparam int N     = cct_pkg::DIST_W;
  localparam int REM_W = N + 2;

  logic          v_q    [N];
  cct_pkg::ctx_t ctx_q  [N];
  logic [2*N-1:0] rad_q [N];
  logic [REM_W-1:0] rem_q [N];
  logic [N-1:0]  root_q [N];

  for (genvar i = 0; i < N; i++) begin : g_st
    logic             v_in;
    cct_pkg::ctx_t    c_in;
    logic [2*N-1:0]   rad_in;
    logic [REM_W-1:0] rem_in;
    logic [N-1:0]     root_in;
    logic [REM_W+1:0] rem_sh, trial;
    logic             take;

    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign c_in    = ctx_i;
      assign rad_in  = (2*N)'(dsq_i);
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign c_in    = ctx_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    // bring down two radicand bits, try (4*root + 1)
    assign rem_sh = {rem_in, rad_in[2*N-1 -: 2]};
    assign trial  = (REM_W+2)'({root_in, 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctx_q[i]  <= c_in;
        rad_q[i]  <= rad_in << 2;
        rem_q[i]  <= take ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
        root_q[i] <= {root_in[N-2:0], take};
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign ctx_o   = ctx_q[N-1];
  assign dist_o  = root_q[N-1];

endmodule

// ----- hdl/cct_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider for both normal components, one bit per stage.
// Depends on cct_pkg.
module cct_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  cct_pkg::ctx_t               ctx_i,
  input  logic [cct_pkg::DIST_W-1:0]  dist_i,
  output logic                        valid_o,
  output cct_pkg::ctx_t               ctx_o,
  output logic [cct_pkg::DIST_W-1:0]  dist_o,
  output logic [cct_pkg::QUO_W-1:0]   qx_o,
  output logic [cct_pkg::QUO_W-1:0]   qy_o
);

  localparam int N = cct_pkg::QUO_W;
  localparam int D = cct_pkg::DIST_W;

  logic          v_q    [N];
  cct_pkg::ctx_t ctx_q  [N];
  logic [D-1:0]  dist_q [N];
  logic [D-1:0]  remx_q [N];
  logic [D-1:0]  remy_q [N];
  logic [N-1:0]  qx_q   [N];
  logic [N-1:0]  qy_q   [N];

  for (genvar i = 0; i < N; i++) begin : g_st
    logic          v_in;
    cct_pkg::ctx_t c_in;
    logic [D-1:0]  d_in;
    logic [D:0]    rx_s, ry_s, dv;
    logic [N-1:0]  qx_in, qy_in;
    logic          tx, ty;

    // magnitude never exceeds the distance, so the first bit weighs 2^14
    if (i == 0) begin : g_first
      assign v_in  = valid_i;
      assign c_in  = ctx_i;
      assign d_in  = dist_i;
      assign rx_s  = (D+1)'(ctx_i.mag_x);
      assign ry_s  = (D+1)'(ctx_i.mag_y);
      assign qx_in = '0;
      assign qy_in = '0;
    end else begin : g_next
      assign v_in  = v_q[i-1];
      assign c_in  = ctx_q[i-1];
      assign d_in  = dist_q[i-1];
      assign rx_s  = {remx_q[i-1], 1'b0};
      assign ry_s  = {remy_q[i-1], 1'b0};
      assign qx_in = qx_q[i-1];
      assign qy_in = qy_q[i-1];
    end

    assign dv = {1'b0, d_in};
    assign tx = (rx_s >= dv);
    assign ty = (ry_s >= dv);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctx_q[i]  <= c_in;
        dist_q[i] <= d_in;
        remx_q[i] <= tx ? D'(rx_s - dv) : rx_s[D-1:0];
        remy_q[i] <= ty ? D'(ry_s - dv) : ry_s[D-1:0];
        qx_q[i]   <= {qx_in[N-2:0], tx};
        qy_q[i]   <= {qy_in[N-2:0], ty};
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign ctx_o   = ctx_q[N-1];
  assign dist_o  = dist_q[N-1];
  assign qx_o    = qx_q[N-1];
  assign qy_o    = qy_q[N-1];

endmodule

// ----- hdl/cct_back.sv -----
`timescale 1ns / 1ps
// Back end: signed normals, circle contact point, depth, saturation.
// Two register stages, the second is the output register. Depends on cct_pkg.
module cct_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  cct_pkg::ctx_t               ctx_i,
  input  logic [cct_pkg::DIST_W-1:0]  dist_i,
  input  logic [cct_pkg::QUO_W-1:0]   qx_i,
  input  logic [cct_pkg::QUO_W-1:0]   qy_i,
  output logic                        valid_o,
  output cct_pkg::out_t               out_o
);

  localparam int PW = cct_pkg::PROD_W;

  logic [1:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[0], valid_i};
    end
  end

  // stage a: zero distance gives a zero normal
  logic [cct_pkg::QUO_W-1:0] nxq_w, nyq_w;
  assign nxq_w = (dist_i == '0) ? '0 : qx_i;
  assign nyq_w = (dist_i == '0) ? '0 : qy_i;

  cct_pkg::ctx_t              ctx_a_q;
  logic [cct_pkg::DIST_W-1:0] dist_a_q;
  logic signed [15:0]         nx_a_q, ny_a_q;
  logic [PW-1:0]              px_a_q, py_a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_a_q  <= ctx_i;
      dist_a_q <= dist_i;
      nx_a_q   <= ctx_i.neg_x ? -$signed(16'(nxq_w)) : $signed(16'(nxq_w));
      ny_a_q   <= ctx_i.neg_y ? -$signed(16'(nyq_w)) : $signed(16'(nyq_w));
      px_a_q   <= PW'(nxq_w) * PW'(ctx_i.self_radius);
      py_a_q   <= PW'(nyq_w) * PW'(ctx_i.self_radius);
    end
  end

  // stage b: offset truncates toward zero, so shift the magnitude then sign it
  logic signed [41:0] offx_w, offy_w, bx_w, by_w, hx_w, hy_w, dep_w;
  cct_pkg::out_t      res_w;

  assign offx_w = $signed(42'(px_a_q[PW-1:cct_pkg::NORM_BITS]));
  assign offy_w = $signed(42'(py_a_q[PW-1:cct_pkg::NORM_BITS]));
  assign bx_w   = {{10{ctx_a_q.base_x[31]}}, ctx_a_q.base_x};
  assign by_w   = {{10{ctx_a_q.base_y[31]}}, ctx_a_q.base_y};
  assign hx_w   = ctx_a_q.neg_x ? (bx_w - offx_w) : (bx_w + offx_w);
  assign hy_w   = ctx_a_q.neg_y ? (by_w - offy_w) : (by_w + offy_w);
  assign dep_w  = $signed(42'(ctx_a_q.rad)) - $signed(42'(dist_a_q));

  always_comb begin
    res_w = '0;
    unique case (ctx_a_q.kind)
      cct_pkg::KIND_CIRCLE: begin
        res_w.colliding = ctx_a_q.hit;
        res_w.hit_x     = cct_pkg::sat32(hx_w);
        res_w.hit_y     = cct_pkg::sat32(hy_w);
        res_w.normal_x  = nx_a_q;
        res_w.normal_y  = ny_a_q;
        res_w.depth     = cct_pkg::sat32(dep_w);
      end
      cct_pkg::KIND_BOX: begin
        res_w.colliding = ctx_a_q.hit;
        res_w.hit_x     = ctx_a_q.base_x;
        res_w.hit_y     = ctx_a_q.base_y;
        res_w.normal_x  = nx_a_q;
        res_w.normal_y  = ny_a_q;
        res_w.depth     = cct_pkg::sat32(dep_w);
      end
      default: begin
        res_w = '0;
      end
    endcase
  end

  cct_pkg::out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= res_w;
    end
  end

  assign valid_o = v_q[1];
  assign out_o   = out_q;

endmodule

// ----- hdl/circle_collision_test_core.sv -----
`timescale 1ns / 1ps
// Circle collision test core: circle against circle or box, one item per cycle while no result is stalled.
// Instantiates cct_front, cct_sqrt, cct_div, cct_back; depends on cct_pkg.
// An accepted item passes through front, sqrt, div and back, in that order, before its result is valid.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// The square root and the normal divider each resolve one bit per stage, which sets the depth.
// Reset: asynchronous active-low rst_ni clears all valid bits; payload registers are not reset.
module circle_collision_test_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cct_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cct_pkg::out_t out_o
);

  // Single pipeline enable: every stage moves unless the output register
  // holds a result that the sink is stalling. Bubbles move with the rest.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  logic                       f_valid;
  cct_pkg::ctx_t              f_ctx;
  logic [cct_pkg::SQ_W-1:0]   f_dsq;

  // scaling, clamp, squared distance and overlap decision
  cct_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .in_i    (in_i),
    .valid_o (f_valid),
    .ctx_o   (f_ctx),
    .dsq_o   (f_dsq)
  );

  logic                       s_valid;
  cct_pkg::ctx_t              s_ctx;
  logic [cct_pkg::DIST_W-1:0] s_dist;

  // floor(sqrt(dx^2 + dy^2)), one root bit per stage
  cct_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (f_valid),
    .ctx_i   (f_ctx),
    .dsq_i   (f_dsq),
    .valid_o (s_valid),
    .ctx_o   (s_ctx),
    .dist_o  (s_dist)
  );

  logic                       d_valid;
  cct_pkg::ctx_t              d_ctx;
  logic [cct_pkg::DIST_W-1:0] d_dist;
  logic [cct_pkg::QUO_W-1:0]  d_qx, d_qy;

  // |d| * 2^14 / dist for both axes
  cct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_valid),
    .ctx_i   (s_ctx),
    .dist_i  (s_dist),
    .valid_o (d_valid),
    .ctx_o   (d_ctx),
    .dist_o  (d_dist),
    .qx_o    (d_qx),
    .qy_o    (d_qy)
  );

  // normals, contact point, depth; output register lives here
  cct_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (d_valid),
    .ctx_i   (d_ctx),
    .dist_i  (d_dist),
    .qx_i    (d_qx),
    .qy_i    (d_qy),
    .valid_o (out_valid_o),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  // an overlap always means non-negative penetration
  a_depth_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.colliding) |-> !out_o.depth[31])
    else $error("colliding result with negative depth");

  // normal components never exceed unit length
  a_normal_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_o.normal_x) <= 16'sd16384 &&
                     $signed(out_o.normal_x) >= -16'sd16384))
    else $error("normal_x out of unit range");

  a_normal_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_o.normal_y) <= 16'sd16384 &&
                     $signed(out_o.normal_y) >= -16'sd16384))
    else $error("normal_y out of unit range");

  // input side is held exactly while the output register is blocked
  a_stall_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($past(in_stall_o) && $stable(out_o)))
    else $error("pipeline moved while the result was stalled");
`endif

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for circle_collision_test_core: directed table, then random pairs.
// Depends on cct_pkg and the core; results checked against a local predictor or fixed expected results.
module tb_top;

  import cct_pkg::*;

  localparam int LATENCY     = 59;
  localparam int N_RANDOM    = 1750;
  localparam int WDOG_LIMIT  = 20000;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  logic  clk_i;
  logic  rst_ni;
  logic  in_valid_i;
  logic  in_stall_o;
  in_t   in_i;
  logic  out_valid_o;
  logic  out_stall_i;
  out_t  out_o;

  circle_collision_test_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // results still owed by the core, oldest first
  out_t contact_q[$];
  int   errors;
  int   idle_cycles;
  int   send_idle_pct;
  int   recv_stall_pct;

  // ---------------------------------------------------------------------------
  // Predictor: exact-width integer math, one result per pair
  // ---------------------------------------------------------------------------
  function automatic logic [34:0] isqrt68(input logic [67:0] v);
    logic [34:0]  r;
    logic [34:0]  c;
    logic [69:0]  c2;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c  = r | (35'd1 << b);
      c2 = {35'd0, c} * {35'd0, c};
      if (c2 <= {2'b00, v}) begin
        r = c;
      end
    end
    return r;
  endfunction

  function automatic longint unit_comp(input longint d, input logic [34:0] len);
    logic [63:0] q;
    logic [63:0] m;
    if (len == 0) begin
      return 0;
    end
    m = (d < 0) ? -d : d;
    q = (m << NORM_BITS) / {29'd0, len};
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic out_t predict_contact(input in_t p);
    out_t        r;
    longint      sx, sy, ox, oy, dx, dy, tx, ty, hw, hh, nx, ny, hx, hy, dep;
    logic [63:0] own_r, tot, mx, my;
    logic [67:0] dsq;
    logic [79:0] rsq;
    logic [34:0] span;
    logic        hit;
    sx = longint'(p.self_x);
    sy = longint'(p.self_y);
    ox = longint'(p.other_x);
    oy = longint'(p.other_y);
    own_r = (64'(p.self_radius) * 64'(p.self_scale)) >> SCALE_BITS;
    hit = 1'b0;
    hx = 0; hy = 0; nx = 0; ny = 0; dep = 0;
    if (p.action == KIND_CIRCLE || p.action == KIND_BOX) begin
      if (p.action == KIND_CIRCLE) begin
        tot = own_r + ((64'(p.other_radius) * 64'(p.other_scale_x)) >> SCALE_BITS);
        tx = ox;
        ty = oy;
      end else begin
        tot = own_r;
        hw = longint'((64'(p.other_width) * 64'(p.other_scale_x)) >> (SCALE_BITS + 1));
        hh = longint'((64'(p.other_height) * 64'(p.other_scale_y)) >> (SCALE_BITS + 1));
        tx = (sx < ox - hw) ? ox - hw : (sx > ox + hw) ? ox + hw : sx;
        ty = (sy < oy - hh) ? oy - hh : (sy > oy + hh) ? oy + hh : sy;
      end
      dx = sx - tx;
      dy = sy - ty;
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      dsq = 68'(mx) * 68'(mx) + 68'(my) * 68'(my);
      rsq = 80'(tot) * 80'(tot);
      // circle pairs need strict overlap, boxes allow touching
      hit = (p.action == KIND_CIRCLE) ? (80'(dsq) < rsq) : (80'(dsq) <= rsq);
      span = isqrt68(dsq);
      nx = unit_comp(dx, span);
      ny = unit_comp(dy, span);
      if (p.action == KIND_CIRCLE) begin
        // contact uses the unscaled own radius, truncated toward zero
        hx = ox + (nx * longint'(p.self_radius)) / 16384;
        hy = oy + (ny * longint'(p.self_radius)) / 16384;
      end else begin
        hx = tx;
        hy = ty;
      end
      dep = longint'(tot) - longint'(span);
    end
    r.colliding = hit;
    r.hit_x     = clip32(hx);
    r.hit_y     = clip32(hy);
    r.normal_x  = nx[15:0];
    r.normal_y  = ny[15:0];
    r.depth     = clip32(dep);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one item per call, falling-edge updates
  // ---------------------------------------------------------------------------
  task automatic send_pair(input in_t p, input bit has_fixed, input out_t fixed);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_i       <= p;
    in_valid_i <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    contact_q.push_back(has_fixed ? fixed : predict_contact(p));
    @(negedge clk_i);
  endtask

  // receiver stall, redrawn every falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (contact_q.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = contact_q.pop_front();
          if (out_o.colliding !== e.colliding) begin
            $error("colliding exp %0d got %0d", e.colliding, out_o.colliding);
            errors++;
          end
          if (out_o.hit_x !== e.hit_x) begin
            $error("hit_x exp %0d got %0d", e.hit_x, out_o.hit_x);
            errors++;
          end
          if (out_o.hit_y !== e.hit_y) begin
            $error("hit_y exp %0d got %0d", e.hit_y, out_o.hit_y);
            errors++;
          end
          if (out_o.normal_x !== e.normal_x) begin
            $error("normal_x exp %0d got %0d", e.normal_x, out_o.normal_x);
            errors++;
          end
          if (out_o.normal_y !== e.normal_y) begin
            $error("normal_y exp %0d got %0d", e.normal_y, out_o.normal_y);
            errors++;
          end
          if (out_o.depth !== e.depth) begin
            $error("depth exp %0d got %0d", e.depth, out_o.depth);
            errors++;
          end
        end
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WDOG_LIMIT);
        $display("** circle_collision_test_core: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Random pair: mostly near-range geometry so hits and misses both occur,
  // some fully random fields (saturation, far apart), a few unknown kinds.
  function automatic in_t rand_pair();
    in_t p;
    int  mode;
    p = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom});
    mode = $urandom_range(99);
    p.action = (mode < 45) ? KIND_CIRCLE : (mode < 90) ? KIND_BOX : 2'($urandom);
    if ($urandom_range(99) < 75) begin
      p.other_x       = $signed($urandom) >>> $urandom_range(31, 8);
      p.other_y       = $signed($urandom) >>> $urandom_range(31, 8);
      p.self_x        = p.other_x + ($signed($urandom) >>> $urandom_range(31, 10));
      p.self_y        = p.other_y + ($signed($urandom) >>> $urandom_range(31, 10));
      p.self_radius   = 31'($urandom) >> $urandom_range(30, 10);
      p.other_radius  = 31'($urandom) >> $urandom_range(30, 10);
      p.other_width   = 31'($urandom) >> $urandom_range(30, 9);
      p.other_height  = 31'($urandom) >> $urandom_range(30, 9);
      p.self_scale    = 16'($urandom_range(512));
      p.other_scale_x = 16'($urandom_range(512));
      p.other_scale_y = 16'($urandom_range(512));
      // exact axis alignment gives pure-axis normals and boundary contact
      if ($urandom_range(9) == 0) begin
        p.self_y = p.other_y;
      end
    end
    return p;
  endfunction

  typedef struct {
    in_t  pair;
    bit   has_fixed;
    out_t fixed;
  } dir_row_t;

  dir_row_t dir_rows[$];
  out_t     zero_res;
  out_t     res;
  in_t      p;

  function automatic in_t base_pair(input logic [1:0] k);
    in_t b;
    b = '0;
    b.action        = k;
    b.self_scale    = 16'h0100;
    b.other_scale_x = 16'h0100;
    b.other_scale_y = 16'h0100;
    return b;
  endfunction

  task automatic add_row(input in_t pr, input bit hf, input out_t fx);
    dir_row_t r;
    r.pair = pr;
    r.has_fixed = hf;
    r.fixed = fx;
    dir_rows.push_back(r);
  endtask

  initial begin
    errors         = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_i           = '0;
    out_stall_i    = 1'b0;
    zero_res       = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    // unknown kinds: all-zero result, even with busy fields
    p = in_t'('1);
    p.action = KIND_UNKNOWN;
    add_row(p, 1, zero_res);
    p.action = KIND_SPARE;
    add_row(p, 1, zero_res);
    // coincident circles: zero normal, contact at other center, unit radius
    p = base_pair(KIND_CIRCLE);
    p.self_radius = 31'h10000;
    res = zero_res;
    res.colliding = 1'b1;
    res.depth = 32'sh10000;
    add_row(p, 1, res);
    // coincident zero-size circles: distance 0, strict compare misses
    add_row(base_pair(KIND_CIRCLE), 1, zero_res);
    // zero-size box at the own center: touching counts
    res = zero_res;
    res.colliding = 1'b1;
    add_row(base_pair(KIND_BOX), 1, res);
    // circles exactly touching along x: strict compare misses
    p = base_pair(KIND_CIRCLE);
    p.self_x = 32'sh20000;
    p.self_radius = 31'h10000;
    p.other_radius = 31'h10000;
    res = zero_res;
    res.hit_x = 32'sh10000;
    res.normal_x = 16'sh4000;
    add_row(p, 1, res);
    // box edge touching along -y
    p = base_pair(KIND_BOX);
    p.self_y = -32'sh30000;
    p.self_radius = 31'h10000;
    p.other_width = 31'h40000;
    p.other_height = 31'h40000;
    res = zero_res;
    res.colliding = 1'b1;
    res.hit_y = -32'sh20000;
    res.normal_y = -16'sh4000;
    add_row(p, 1, res);
    // extreme corners: saturating contact and depth
    p = base_pair(KIND_CIRCLE);
    p.self_x = 32'sh7FFFFFFF; p.self_y = 32'sh7FFFFFFF;
    p.other_x = 32'sh80000000; p.other_y = 32'sh80000000;
    add_row(p, 0, zero_res);
    p.self_radius = '1; p.other_radius = '1;
    p.self_scale = '1; p.other_scale_x = '1;
    add_row(p, 0, zero_res);
    p.self_x = 32'sh80000000; p.other_x = 32'sh7FFFFFFF;
    add_row(p, 0, zero_res);
    p.action = KIND_BOX;
    p.other_width = '1; p.other_height = '1; p.other_scale_y = '1;
    add_row(p, 0, zero_res);
    p.other_width = '0; p.other_height = '0;
    add_row(p, 0, zero_res);
    // huge circle contact overflows into saturation
    p = base_pair(KIND_CIRCLE);
    p.self_x = 32'sh7FFFF000;
    p.other_x = 32'sh70000000;
    p.self_radius = '1;
    add_row(p, 0, zero_res);
    // own center inside a big box
    p = base_pair(KIND_BOX);
    p.self_x = 32'sh12345; p.self_y = -32'sh54321;
    p.self_radius = 31'h8000;
    p.other_width = 31'h100000; p.other_height = 31'h100000;
    add_row(p, 0, zero_res);
    // diagonal separation, scaled radii
    p = base_pair(KIND_CIRCLE);
    p.self_x = -32'sh30000; p.self_y = 32'sh40000;
    p.self_radius = 31'h20000; p.self_scale = 16'h0180;
    p.other_radius = 31'h30000; p.other_scale_x = 16'h0080;
    add_row(p, 0, zero_res);
    p.action = KIND_BOX;
    p.other_width = 31'h20000; p.other_height = 31'h10000;
    p.other_scale_y = 16'h0300;
    add_row(p, 0, zero_res);

    foreach (dir_rows[i]) begin
      send_pair(dir_rows[i].pair, dir_rows[i].has_fixed, dir_rows[i].fixed);
    end

    // Random part in idling phases: none, sender, receiver, both, then none again
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        3: begin send_idle_pct = 31; recv_stall_pct = 31; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        send_pair(rand_pair(), 0, zero_res);
      end
    end
    in_valid_i <= 1'b0;

    // drain, then let the pipe settle
    while (contact_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("** circle_collision_test_core: PASSED **");
    end else begin
      $display("** circle_collision_test_core: FAILED **");
    end
    $finish;
  end

endmodule
